/* design/three_level_priority_queue_top_assert.svh */
// three_level_priority_queue_top_assert.svh: assertion macros for the priority queue top level
// no dependencies; included by three_level_priority_queue_top.sv
`ifndef THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TLPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TLPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tlpq_pkg.sv */
// tlpq_pkg.sv: shared constants, types and the priority pick for the priority queue
// no dependencies; used by tlpq_level_fifo and three_level_priority_queue_top
package tlpq_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int NUM_LEVELS      = 3;
   localparam int LEVEL_W         = 2;
   localparam int STATUS_W        = 2;

   typedef logic [LEVEL_W-1:0]    level_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [NUM_LEVELS-1:0] level_mask_type;

   localparam logic      MODE_PUSH = 1'b0;
   localparam logic      MODE_POP  = 1'b1;

   localparam level_type LEVEL_LOW    = 2'd0;
   localparam level_type LEVEL_NORMAL = 2'd1;
   localparam level_type LEVEL_HIGH   = 2'd2;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_FULL_DROP = 2'd1;
   localparam status_type STATUS_POP_EMPTY = 2'd2;

   // per level operation request
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // per level occupancy flags
   typedef struct packed {
      logic empty;
      logic full;
      logic last;
   } fifo_stat_type;

   // highest non-empty level; low when nothing is present
   function automatic level_type pick_top(input level_mask_type ne);
      level_type top;
      top = LEVEL_LOW;
      if (ne[LEVEL_HIGH]) begin
         top = LEVEL_HIGH;
      end else if (ne[LEVEL_NORMAL]) begin
         top = LEVEL_NORMAL;
      end
      return top;
   endfunction

endpackage

/* design/three_level_priority_queue_top.sv */
// three_level_priority_queue_top.sv: strict priority queue with three fifo levels
// depends on tlpq_pkg, tlpq_level_fifo and three_level_priority_queue_top_assert.svh
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low. req_mode
//   selects push (req_value stored at req_level, 0 low, 1 normal, 2 high) or pop
//   (head of the highest non-empty level removed; req_value and req_level ignored).
//   Each transaction gives one result: rsp_strobe is high for one cycle with
//   rsp_status (done, push dropped on a full level, pop on empty ignored) and the
//   front after the operation: rsp_head_value, rsp_head_level, rsp_not_empty.
//   A push to level 3 is ignored and reports done.
//   The request passes through the input register and the operation register into
//   the result register, whose output drives rsp_strobe.
//   Throughput: one transaction per cycle while reset is low; pointers and counts
//   are registered and each level's head comes from a registered memory read at the
//   next read pointer.
//   Reset: busy is high while reset is asserted; all levels are emptied at once.
//   The receiver cannot stall; results are never held back.
module three_level_priority_queue_top #(
   parameter int DATA_WIDTH  = tlpq_pkg::DATA_WIDTH_DEF,
   parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [DATA_WIDTH-1:0]         req_value,
   input  logic [tlpq_pkg::LEVEL_W-1:0]  req_level,
   output logic                          rsp_strobe,
   output logic [tlpq_pkg::STATUS_W-1:0] rsp_status,
   output logic [DATA_WIDTH-1:0]         rsp_head_value,
   output logic [tlpq_pkg::LEVEL_W-1:0]  rsp_head_level,
   output logic                          rsp_not_empty
);

   localparam int NL = tlpq_pkg::NUM_LEVELS;

   // input register
   logic                 a_valid_ff;
   logic                 a_mode_ff;
   logic [DATA_WIDTH-1:0] a_value_ff;
   tlpq_pkg::level_type  a_level_ff;

   // operation register
   logic                 b_valid_ff;
   tlpq_pkg::status_type b_status_ff, b_status_in;
   tlpq_pkg::level_type  b_top_ff, b_top_in;
   logic                 b_not_empty_ff, b_not_empty_in;

   // result register
   logic                  rsp_strobe_ff;
   tlpq_pkg::status_type  rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_head_value_ff, rsp_head_value_in;
   tlpq_pkg::level_type   rsp_head_level_ff, rsp_head_level_in;
   logic                  rsp_not_empty_ff;

   tlpq_pkg::fifo_ctrl_type ctrl [NL];
   tlpq_pkg::fifo_stat_type stat [NL];
   logic [DATA_WIDTH-1:0]   head_data [NL];
   tlpq_pkg::level_mask_type ne_cur, ne_next;
   tlpq_pkg::level_type      top_cur;

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      if (accept) begin
         a_mode_ff  <= req_mode;
         a_value_ff <= req_value;
         a_level_ff <= req_level;
      end
   end

   for (genvar l = 0; l < NL; l++) begin : g_level
      assign ne_cur[l] = !stat[l].empty;

      tlpq_level_fifo #(
         .DATA_WIDTH  (DATA_WIDTH),
         .LEVEL_DEPTH (LEVEL_DEPTH)
      ) u_fifo (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[l]),
         .wr_data   (a_value_ff),
         .head_data (head_data[l]),
         .stat      (stat[l])
      );
   end

   assign top_cur = tlpq_pkg::pick_top(ne_cur);

   always_comb begin
      for (int l = 0; l < NL; l++) begin
         ctrl[l] = '0;
      end
      b_status_in = tlpq_pkg::STATUS_DONE;
      ne_next     = ne_cur;
      if (a_valid_ff) begin
         if (a_mode_ff == tlpq_pkg::MODE_PUSH) begin
            // level 3 is not a queue: ignored with status done
            if (a_level_ff <= tlpq_pkg::LEVEL_HIGH) begin
               if (stat[a_level_ff].full) begin
                  b_status_in = tlpq_pkg::STATUS_FULL_DROP;
               end else begin
                  ctrl[a_level_ff].push = 1'b1;
                  ne_next[a_level_ff]   = 1'b1;
               end
            end
         end else if (ne_cur == '0) begin
            b_status_in = tlpq_pkg::STATUS_POP_EMPTY;
         end else begin
            ctrl[top_cur].pop = 1'b1;
            if (stat[top_cur].last) begin
               ne_next[top_cur] = 1'b0;
            end
         end
      end
      b_top_in       = tlpq_pkg::pick_top(ne_next);
      b_not_empty_in = |ne_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_status_ff    <= b_status_in;
      b_top_ff       <= b_top_in;
      b_not_empty_ff <= b_not_empty_in;
   end

   // head registers already hold the front after the operation
   always_comb begin
      rsp_head_value_in = '0;
      rsp_head_level_in = tlpq_pkg::LEVEL_LOW;
      if (b_not_empty_ff) begin
         rsp_head_value_in = head_data[b_top_ff];
         rsp_head_level_in = b_top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= b_valid_ff;
      end
      rsp_status_ff     <= b_status_ff;
      rsp_head_value_ff <= rsp_head_value_in;
      rsp_head_level_ff <= rsp_head_level_in;
      rsp_not_empty_ff  <= b_not_empty_ff;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_value = rsp_head_value_ff;
   assign rsp_head_level = rsp_head_level_ff;
   assign rsp_not_empty  = rsp_not_empty_ff;

`include "three_level_priority_queue_top_assert.svh"

   `TLPQ_ASSERT_NEXT(a_result_follows, accept, ##2 rsp_strobe, "result strobe missing")
   `TLPQ_ASSERT_SAME(a_empty_front_zero, rsp_strobe && !rsp_not_empty, (rsp_head_value == '0) && (rsp_head_level == tlpq_pkg::LEVEL_LOW), "empty front not zero")
   `TLPQ_ASSERT_SAME(a_pop_empty_consistent, b_valid_ff && (b_status_ff == tlpq_pkg::STATUS_POP_EMPTY), !b_not_empty_ff, "pop on empty with elements present")
   `TLPQ_ASSERT_NEXT(a_push_fills, a_valid_ff && (a_mode_ff == tlpq_pkg::MODE_PUSH) && (a_level_ff <= tlpq_pkg::LEVEL_HIGH), b_not_empty_ff, "queue empty after push")

endmodule

/* design/tlpq_level_fifo.sv */
// tlpq_level_fifo.sv: one priority level, a circular buffer with a registered head read
// depends on tlpq_pkg for the control and status structs
module tlpq_level_fifo #(
   parameter int DATA_WIDTH  = tlpq_pkg::DATA_WIDTH_DEF,
   parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlpq_pkg::fifo_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]   wr_data,
   output logic [DATA_WIDTH-1:0]   head_data,
   output tlpq_pkg::fifo_stat_type stat
);

   localparam int PTR_W = $clog2(LEVEL_DEPTH);
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(LEVEL_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(LEVEL_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] mem_ff [LEVEL_DEPTH];
   logic [DATA_WIDTH-1:0] head_ff;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // head is read at the next read pointer; a push into an empty level forwards its data
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
      if (ctrl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wr_data;
      end else begin
         head_ff <= mem_ff[rd_ptr_in];
      end
   end

   assign head_data  = head_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.last  = (count_ff == CNT_ONE);

endmodule
